[hdl/osmo_pkg.sv]
// ----------------------------------------------------------------------------
// osmo_pkg
// Shared types and codes for the order-statistic multiset with offset.
// ----------------------------------------------------------------------------
package osmo_pkg;

   localparam int DATA_W = 32;

   // action codes of an input transaction
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_RAISE  = 2'd1;
   localparam logic [1:0] ACT_LOWER  = 2'd2;
   localparam logic [1:0] ACT_QUERY  = 2'd3;

   // commands broadcast to every cell of the chain
   localparam logic [1:0] CMD_HOLD    = 2'd0;
   localparam logic [1:0] CMD_INSERT  = 2'd1;
   localparam logic [1:0] CMD_MARK    = 2'd2;
   localparam logic [1:0] CMD_COMPACT = 2'd3;

   // register byte-address bit that selects the register index
   localparam logic REG_MIN_LEVEL = 1'b0;

   typedef struct packed {
      logic [1:0]               action;
      logic signed [DATA_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] kth_value;
      logic                     not_found;
      logic                     store_full;
      logic [DATA_W-1:0]        departed_total;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [DATA_W-1:0] value;   // stored value to insert
      logic [DATA_W-1:0] offset;  // global offset
      logic [DATA_W-1:0] limit;   // minimum level
   } chain_cmd_type;

endpackage

[hdl/osmo_cell.sv]
// ----------------------------------------------------------------------------
// osmo_cell
// One slot of the sorted chain: holds a stored value and an occupied bit,
// and trades values with its neighbors on insert and compaction.
// ----------------------------------------------------------------------------
module osmo_cell
   import osmo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  chain_cmd_type     cmd,
   input  logic              prev_lt,
   input  logic              prev_vld,
   input  logic [DATA_W-1:0] prev_val,
   input  logic              next_vld,
   input  logic [DATA_W-1:0] next_val,
   output logic              lt,
   output logic              vld,
   output logic [DATA_W-1:0] val,
   output logic              pair
);

   logic              vld_ff, vld_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] real_val;

   assign lt       = vld_ff && ($signed(val_ff) < $signed(cmd.value));
   assign real_val = val_ff + cmd.offset;
   // hole directly under an occupied neighbor
   assign pair     = !vld_ff && next_vld;
   assign vld      = vld_ff;
   assign val      = val_ff;

   always_comb begin
      vld_in = vld_ff;
      val_in = val_ff;
      unique case (cmd.op)
         CMD_INSERT: begin
            if (!lt) begin
               if (prev_lt) begin
                  vld_in = 1'b1;
                  val_in = cmd.value;
               end else begin
                  vld_in = prev_vld;
                  val_in = prev_val;
               end
            end
         end
         CMD_MARK: begin
            if (vld_ff && ($signed(real_val) < $signed(cmd.limit))) begin
               vld_in = 1'b0;
            end
         end
         CMD_COMPACT: begin
            if (!vld_ff && next_vld) begin
               vld_in = 1'b1;
               val_in = next_val;
            end else if (vld_ff && !prev_vld) begin
               vld_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

[hdl/osmo_chain.sv]
// ----------------------------------------------------------------------------
// osmo_chain
// Row of cells in ascending stored order, with the position select and the
// compaction status taken across the row.
// ----------------------------------------------------------------------------
module osmo_chain
   import osmo_pkg::*;
#(
   parameter int CAPACITY = 1024,
   localparam int IDX_W   = $clog2(CAPACITY)
)
(
   input  logic                clock,
   input  logic                reset,
   input  chain_cmd_type       cmd,
   input  logic [IDX_W-1:0]    sel_idx,
   output logic [DATA_W-1:0]   sel_val,
   output logic [CAPACITY-1:0] vld_vec,
   output logic                any_pair
);

   logic [CAPACITY-1:0]   lt_vec;
   logic [CAPACITY-1:0]   pair_vec;
   logic [DATA_W-1:0]     val_arr [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic              p_lt, p_vld, n_vld;
      logic [DATA_W-1:0] p_val, n_val;

      if (i == 0) begin : g_first
         assign p_lt  = 1'b1;
         assign p_vld = 1'b1;
         assign p_val = '0;
      end else begin : g_mid
         assign p_lt  = lt_vec[i-1];
         assign p_vld = vld_vec[i-1];
         assign p_val = val_arr[i-1];
      end

      if (i == CAPACITY-1) begin : g_last
         assign n_vld = 1'b0;
         assign n_val = '0;
      end else begin : g_inner
         assign n_vld = vld_vec[i+1];
         assign n_val = val_arr[i+1];
      end

      osmo_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .prev_lt  (p_lt),
         .prev_vld (p_vld),
         .prev_val (p_val),
         .next_vld (n_vld),
         .next_val (n_val),
         .lt       (lt_vec[i]),
         .vld      (vld_vec[i]),
         .val      (val_arr[i]),
         .pair     (pair_vec[i])
      );
   end

   assign any_pair = |pair_vec;

   // AND-OR select by position
   always_comb begin
      sel_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (sel_idx == IDX_W'(i)) begin
            sel_val = sel_val | val_arr[i];
         end
      end
   end

endmodule

[hdl/order_statistic_multiset_offset.sv]
// ----------------------------------------------------------------------------
// order_statistic_multiset_offset
// Sorted multiset of values held relative to a global offset, built as a
// chain of cells. Insert, raise and query are captured in the idle state and
// done in the exec state, in which every cell compares and shifts in parallel
// (insert) or the position select reads one cell (query); exec waits while a
// result is held and rsp_ready is low. Lower passes through exec, mark and
// compact: evicted cells leave holes that travel up one cell per cycle, and
// compaction ends once no hole is left and the result register is free. A new
// request is taken once the previous one has finished its work; the result
// register lets it be taken while the previous result still waits on rsp_ready.
// ----------------------------------------------------------------------------
module order_statistic_multiset_offset
   import osmo_pkg::*;
#(
   parameter int CAPACITY = 1024
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_EXEC    = 2'd1;
   localparam logic [1:0] ST_MARK    = 2'd2;
   localparam logic [1:0] ST_COMPACT = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        act_ff, act_in;
   logic [DATA_W-1:0] op_ff, op_in;
   logic [IDX_W-1:0]  sel_idx_ff, sel_idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] offset_ff, offset_in;
   logic [DATA_W-1:0] evicted_ff, evicted_in;
   logic [DATA_W-1:0] min_ff, min_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   chain_cmd_type       cmd;
   logic [DATA_W-1:0]   sel_val;
   logic [CAPACITY-1:0] vld_vec;
   logic                any_pair;

   logic              out_free;
   logic              req_fire;
   logic [CNT_W-1:0]  cnt_m1;
   logic [IDX_W-1:0]  top_idx;
   logic              top_vld;
   logic              store_is_full;
   logic              below_min;
   logic              rank_bad;
   logic              compact_done;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MIN_LEVEL) ? min_ff : '0;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cnt_m1        = cnt_ff - CNT_W'(1);
   assign top_idx       = cnt_m1[IDX_W-1:0];
   assign top_vld       = vld_vec[top_idx];
   assign store_is_full = (cnt_ff == CNT_W'(CAPACITY));
   assign below_min     = $signed(op_ff) < $signed(min_ff);
   assign rank_bad      = op_ff[DATA_W-1] || (op_ff == '0) || (op_ff > DATA_W'(cnt_ff));
   assign compact_done  = !any_pair && ((cnt_ff == '0) || top_vld);

   osmo_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sel_idx  (sel_idx_ff),
      .sel_val  (sel_val),
      .vld_vec  (vld_vec),
      .any_pair (any_pair)
   );

   always_comb begin
      min_in = min_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_MIN_LEVEL)) begin
         min_in = csr_pwdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      op_in        = op_ff;
      sel_idx_in   = sel_idx_ff;
      cnt_in       = cnt_ff;
      offset_in    = offset_ff;
      evicted_in   = evicted_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd.op     = CMD_HOLD;
      cmd.value  = op_ff - offset_ff;
      cmd.offset = offset_ff;
      cmd.limit  = min_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               act_in     = req_payload.action;
               op_in      = req_payload.operand;
               sel_idx_in = cnt_ff[IDX_W-1:0] - req_payload.operand[IDX_W-1:0];
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (act_ff == ACT_LOWER) begin
               offset_in = offset_ff - op_ff;
               state_in  = ST_MARK;
            end else if (out_free) begin
               rsp_in.kth_value      = '0;
               rsp_in.not_found      = 1'b0;
               rsp_in.store_full     = 1'b0;
               rsp_in.departed_total = evicted_ff;
               case (act_ff)
                  ACT_INSERT: begin
                     if (!below_min) begin
                        if (store_is_full) begin
                           rsp_in.store_full = 1'b1;
                        end else begin
                           cmd.op = CMD_INSERT;
                           cnt_in = cnt_ff + CNT_W'(1);
                        end
                     end
                  end
                  ACT_RAISE: begin
                     offset_in = offset_ff + op_ff;
                  end
                  default: begin
                     if (rank_bad) begin
                        rsp_in.not_found = 1'b1;
                     end else begin
                        rsp_in.kth_value = sel_val + offset_ff;
                     end
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MARK: begin
            cmd.op   = CMD_MARK;
            state_in = ST_COMPACT;
         end
         default: begin
            cmd.op = CMD_COMPACT;
            // an empty top slot retires one evicted entry
            if ((cnt_ff != '0) && !top_vld) begin
               cnt_in     = cnt_m1;
               evicted_in = evicted_ff + DATA_W'(1);
            end
            if (compact_done && out_free) begin
               rsp_in.kth_value      = '0;
               rsp_in.not_found      = 1'b0;
               rsp_in.store_full     = 1'b0;
               rsp_in.departed_total = evicted_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         offset_ff    <= '0;
         evicted_ff   <= '0;
         min_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         offset_ff    <= offset_in;
         evicted_ff   <= evicted_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      op_ff      <= op_in;
      sel_idx_ff <= sel_idx_in;
      rsp_ff     <= rsp_in;
   end

endmodule

[hdl/osmo_checker.sv]
// ----------------------------------------------------------------------------
// osmo_checker
// Port-level checks on the multiset block, attached by bind.
// ----------------------------------------------------------------------------
module osmo_checker
   import osmo_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed or dropped while stalled");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.not_found && rsp_payload.store_full))
      else $error("not_found and store_full both set");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.not_found |-> rsp_payload.kth_value == '0)
      else $error("kth_value not zero on a missed query");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous transaction in progress");

endmodule

bind order_statistic_multiset_offset osmo_checker u_osmo_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

[sim/order_statistic_multiset_offset_tb.sv]
// ----------------------------------------------------------------------------
// order_statistic_multiset_offset_tb
// Self-checking bench for the offset multiset: a scoreboard class keeps its
// own sorted copy of the store, offset and eviction count, and checks every
// response in order. Directed cases cover rank and wrap corners. Random
// phases under several min_level settings follow, including a fill to
// capacity, with random stalls on both channels and one long response
// hold-off.
// ----------------------------------------------------------------------------
module order_statistic_multiset_offset_tb;
   import osmo_pkg::*;

   localparam int CAP            = 1024;
   localparam int SETTLE         = 2 * CAP + 16;   // worst-case compaction after a lower
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 300;
   localparam logic [31:0] INT_MIN = 32'h8000_0000;
   localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

   class multiset_tracker;
      logic [31:0] stored_q[$];        // value minus offset, ascending as signed
      logic [31:0] offset;
      logic [31:0] evicted;
      logic [31:0] min_level;
      rsp_type     pending_results[$];
      int unsigned error_count;
      int unsigned n_insert, n_refused, n_dropped, n_query, n_miss;
      int unsigned n_raise, n_lower, n_evicted, n_checked;

      function new();
         offset      = '0;
         evicted     = '0;
         min_level   = '0;
         error_count = 0;
         n_insert = 0; n_refused = 0; n_dropped = 0; n_query = 0; n_miss = 0;
         n_raise = 0; n_lower = 0; n_evicted = 0; n_checked = 0;
      endfunction

      function void take_request(req_type r);
         rsp_type     e;
         logic [31:0] sv;
         logic [31:0] real_v;
         logic [31:0] kept[$];
         int          pos;
         int          k;
         e = '0;
         case (r.action)
            ACT_INSERT: begin
               n_insert++;
               if ($signed(r.operand) < $signed(min_level)) begin
                  n_refused++;
               end else if (stored_q.size() >= CAP) begin
                  e.store_full = 1'b1;
                  n_dropped++;
               end else begin
                  sv  = r.operand - offset;
                  pos = 0;
                  while (pos < stored_q.size() && $signed(stored_q[pos]) < $signed(sv))
                     pos++;
                  stored_q.insert(pos, sv);
               end
            end
            ACT_RAISE: begin
               n_raise++;
               offset = offset + r.operand;
            end
            ACT_LOWER: begin
               n_lower++;
               offset = offset - r.operand;
               foreach (stored_q[i]) begin
                  real_v = stored_q[i] + offset;
                  if ($signed(real_v) < $signed(min_level)) begin
                     evicted = evicted + 1;
                     n_evicted++;
                  end else begin
                     kept.push_back(stored_q[i]);
                  end
               end
               stored_q = kept;
            end
            default: begin
               n_query++;
               k = $signed(r.operand);
               if (k < 1 || k > stored_q.size()) begin
                  e.not_found = 1'b1;
                  n_miss++;
               end else begin
                  e.kth_value = stored_q[stored_q.size() - k] + offset;
               end
            end
         endcase
         e.departed_total = evicted;
         pending_results.push_back(e);
      endfunction

      function void match_result(rsp_type got);
         rsp_type e;
         if (pending_results.size() == 0) begin
            $error("result with no transaction outstanding");
            error_count++;
            return;
         end
         e = pending_results.pop_front();
         n_checked++;
         if (got.kth_value !== e.kth_value) begin
            $error("kth_value: expected %0d, got %0d", e.kth_value, got.kth_value);
            error_count++;
         end
         if (got.not_found !== e.not_found) begin
            $error("not_found: expected %0b, got %0b", e.not_found, got.not_found);
            error_count++;
         end
         if (got.store_full !== e.store_full) begin
            $error("store_full: expected %0b, got %0b", e.store_full, got.store_full);
            error_count++;
         end
         if (got.departed_total !== e.departed_total) begin
            $error("departed_total: expected %0d, got %0d",
                   e.departed_total, got.departed_total);
            error_count++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_payload;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   multiset_tracker tracker;
   int              idle_cycles;
   bit              quiet;
   bit              hold_off_request;

   order_statistic_multiset_offset #(.CAPACITY(CAP)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   // transaction monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) tracker.take_request(req_payload);
         if (rsp_valid && rsp_ready) tracker.match_result(rsp_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // response side backpressure
   initial begin
      int gap;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_request = 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   task automatic send_request(input logic [1:0] act, input logic [31:0] opnd);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_payload.action  <= act;
      req_payload.operand <= opnd;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_min_level(input logic [31:0] value);
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_MIN_LEVEL, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.min_level = value;
   endtask

   // mostly meaningful operands near min_level and the current count,
   // with a share of full-range noise
   task automatic send_random();
      int          r;
      int          s;
      int unsigned cnt;
      logic [1:0]  act;
      logic [31:0] opnd;
      cnt = tracker.stored_q.size();
      r   = $urandom_range(0, 99);
      s   = $urandom_range(0, 99);
      if (r < 40) begin
         act = ACT_INSERT;
         if (s < 70)      opnd = tracker.min_level + $urandom_range(0, 3000);
         else if (s < 80) opnd = tracker.min_level - 1;
         else if (s < 90) opnd = tracker.min_level;
         else             opnd = $urandom;
      end else if (r < 72) begin
         act = ACT_QUERY;
         if (s < 60)      opnd = $urandom_range(1, (cnt == 0) ? 1 : cnt);
         else if (s < 70) opnd = '0;
         else if (s < 80) opnd = cnt + 1;
         else if (s < 90) opnd = -$urandom_range(1, 50);
         else             opnd = $urandom;
      end else if (r < 84) begin
         act = ACT_RAISE;
         if (s < 60)      opnd = $urandom_range(0, 400);
         else if (s < 80) opnd = -$urandom_range(1, 400);
         else             opnd = $urandom;
      end else begin
         act = ACT_LOWER;
         if (s < 60)      opnd = $urandom_range(0, 600);
         else if (s < 75) opnd = -$urandom_range(1, 300);
         else if (s < 90) opnd = $urandom;
         else             opnd = '0;
      end
      send_request(act, opnd);
   endtask

   task automatic run_phase(input int n);
      repeat (n) send_random();
   endtask

   initial begin
      int unsigned fill;
      tracker          = new();
      quiet            = 1'b0;
      hold_off_request = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ranks, equal values, refused inserts, offset wrap, eviction
      send_request(ACT_QUERY,  32'd1);
      send_request(ACT_INSERT, 32'd5);
      send_request(ACT_INSERT, 32'd5);
      send_request(ACT_INSERT, -32'sd3);
      send_request(ACT_INSERT, 32'd0);
      send_request(ACT_INSERT, INT_MAX);
      send_request(ACT_INSERT, INT_MIN);
      send_request(ACT_QUERY,  32'd0);
      send_request(ACT_QUERY,  32'hffff_ffff);
      send_request(ACT_QUERY,  INT_MIN);
      send_request(ACT_QUERY,  32'd4);
      send_request(ACT_QUERY,  32'd5);
      send_request(ACT_QUERY,  INT_MAX);
      send_request(ACT_QUERY,  32'd1);
      send_request(ACT_RAISE,  32'd100);
      send_request(ACT_QUERY,  32'd1);
      send_request(ACT_LOWER,  32'd0);
      send_request(ACT_RAISE,  -32'sd200);
      send_request(ACT_LOWER,  32'd0);
      send_request(ACT_QUERY,  32'd1);
      send_request(ACT_INSERT, 32'd3);
      send_request(ACT_RAISE,  INT_MAX);
      send_request(ACT_LOWER,  INT_MIN);
      send_request(ACT_QUERY,  32'd1);
      send_request(ACT_LOWER,  32'hffff_ffff);

      write_min_level(INT_MIN);
      send_request(ACT_INSERT, INT_MIN);
      send_request(ACT_QUERY,  32'd1);
      send_request(ACT_LOWER,  INT_MAX);
      run_phase(80);

      write_min_level(-32'sd1000);
      hold_off_request = 1'b1;   // sender keeps offering while responses back up
      run_phase(85);

      write_min_level(32'd1000);
      run_phase(85);

      write_min_level($urandom);
      run_phase(70);

      // fill to capacity, then hit the full and rank-limit corners
      write_min_level(-32'sd8000);
      fill = CAP - tracker.stored_q.size() + 6;
      repeat (fill) send_request(ACT_INSERT, -32'sd8000 + $urandom_range(0, 8000));
      send_request(ACT_INSERT, -32'sd8001);
      send_request(ACT_QUERY,  CAP);
      send_request(ACT_QUERY,  CAP + 1);
      send_request(ACT_QUERY,  32'd1);
      send_request(ACT_LOWER,  32'd4000);
      send_request(ACT_QUERY,  32'd1);

      write_min_level(INT_MAX);
      send_request(ACT_INSERT, INT_MAX);
      run_phase(60);

      write_min_level(32'd0);
      quiet = 1'b1;
      run_phase(60);
      quiet = 1'b0;
      run_phase(70);

      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Checked %0d results: %0d inserts (%0d refused, %0d dropped when full),",
               tracker.n_checked, tracker.n_insert, tracker.n_refused, tracker.n_dropped);
      $display("%0d queries (%0d not found), %0d raises, %0d lowers evicting %0d entries",
               tracker.n_query, tracker.n_miss, tracker.n_raise, tracker.n_lower,
               tracker.n_evicted);
      if (tracker.error_count == 0 && tracker.pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[order_statistic_multiset_offset.f]
hdl/osmo_pkg.sv
hdl/osmo_cell.sv
hdl/osmo_chain.sv
hdl/order_statistic_multiset_offset.sv
hdl/osmo_checker.sv
sim/order_statistic_multiset_offset_tb.sv
